/* src/sgm_pkg.sv */
package sgm_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int PIXEL_BITS      = 8;
  localparam int CFG_WIDTH_BITS  = 12;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int WIDTH_RESET     = 512;
  localparam int HEIGHT_RESET    = 512;
  localparam int MIN_DIM         = 3;
  localparam int GRAD_BITS       = 11;
  localparam int QUEUE_DEPTH     = 4;
  localparam int MAG_BITS        = 8;
  localparam int MAG_MAX         = 255;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_WIDTH_BITS-1:0]  image_width;
    logic [CFG_HEIGHT_BITS-1:0] image_height;
  } cfg_dims_t;

  // one interior pixel handed from the front to the back
  typedef struct packed {
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
    logic                        row_end;
    logic                        frame_end;
  } grad_req_t;

endpackage

/* src/sgm_queue.sv */
module sgm_queue import sgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  grad_req_t push_data,
  output logic      full,
  input  logic      pop,
  output grad_req_t head,
  output logic      empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  grad_req_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CNTW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/sgm_front.sv */
module sgm_front import sgm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_dims_t             dims,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel_value,
  input  logic                  in_frame_start,
  output logic                  q_push,
  output grad_req_t             q_entry,
  input  logic                  q_full
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCMP = (CW + 1 > CFG_WIDTH_BITS) ? CW + 1 : CFG_WIDTH_BITS;
  localparam int HCMP = CFG_HEIGHT_BITS + 1;
  localparam int SW   = GRAD_BITS - 1;

  // line store: upper row in the high byte, middle row in the low byte
  logic [2*PIXEL_BITS-1:0] lb_mem [MAX_WIDTH];

  logic [CW-1:0]              col_r, col_nxt, col_base;
  logic [CFG_HEIGHT_BITS-1:0] row_r, row_nxt, row_base;
  logic [WCMP-1:0]            w_ext, w_eff;
  logic [CFG_HEIGHT_BITS-1:0] h_eff;
  logic                       last_col, last_row, interior, accept;

  logic                       b_valid_r, b_valid_nxt, b_fire;
  logic [CW-1:0]              b_idx_r;
  logic [PIXEL_BITS-1:0]      b_pix_r;
  logic                       b_interior_r, b_last_col_r, b_last_row_r;
  logic [2*PIXEL_BITS-1:0]    rd_r, fwd_data_r, line_word;
  logic                       fwd_hit_r;
  logic [PIXEL_BITS-1:0]      t2, m2;
  logic [PIXEL_BITS-1:0]      win_r [6];
  logic [SW-1:0]              gx_pos, gx_neg, gy_pos, gy_neg;

  always_comb begin
    w_ext = WCMP'(dims.image_width);
    if (w_ext < WCMP'(MIN_DIM)) begin
      w_eff = WCMP'(MIN_DIM);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (dims.image_height < CFG_HEIGHT_BITS'(MIN_DIM)) ?
            CFG_HEIGHT_BITS'(MIN_DIM) : dims.image_height;

    col_base = in_frame_start ? '0 : col_r;
    row_base = in_frame_start ? '0 : row_r;
    last_col = (WCMP'(col_base) + WCMP'(1)) >= w_eff;
    last_row = (HCMP'(row_base) + HCMP'(1)) >= HCMP'(h_eff);
    interior = (row_base >= CFG_HEIGHT_BITS'(2)) && (WCMP'(col_base) >= WCMP'(2));

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_base + CFG_HEIGHT_BITS'(1);
    end else begin
      col_nxt = col_base + CW'(1);
      row_nxt = row_base;
    end
  end

  // write-then-read on the same column in back-to-back cycles
  assign line_word = fwd_hit_r ? fwd_data_r : rd_r;
  assign t2 = line_word[2*PIXEL_BITS-1:PIXEL_BITS];
  assign m2 = line_word[PIXEL_BITS-1:0];

  assign b_fire   = b_valid_r && (!b_interior_r || !q_full);
  assign in_stall = b_valid_r && !b_fire;
  assign accept   = in_valid && !in_stall;
  assign q_push   = b_valid_r && b_interior_r && !q_full;

  always_comb begin
    gx_pos = SW'(t2) + SW'({m2, 1'b0}) + SW'(b_pix_r);
    gx_neg = SW'(win_r[0]) + SW'({win_r[1], 1'b0}) + SW'(win_r[2]);
    gy_pos = SW'(win_r[2]) + SW'({win_r[5], 1'b0}) + SW'(b_pix_r);
    gy_neg = SW'(win_r[0]) + SW'({win_r[3], 1'b0}) + SW'(t2);
    q_entry.gx        = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    q_entry.gy        = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    q_entry.row_end   = b_last_col_r;
    q_entry.frame_end = b_last_col_r && b_last_row_r;
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r         <= lb_mem[col_base];
      b_idx_r      <= col_base;
      b_pix_r      <= in_pixel_value;
      b_interior_r <= interior;
      b_last_col_r <= last_col;
      b_last_row_r <= last_row;
      fwd_hit_r    <= b_fire && (b_idx_r == col_base);
      fwd_data_r   <= {m2, b_pix_r};
    end
    if (b_fire) begin
      lb_mem[b_idx_r] <= {m2, b_pix_r};
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= t2;
      win_r[4] <= m2;
      win_r[5] <= b_pix_r;
    end
  end

endmodule

/* src/sgm_back.sv */
module sgm_back import sgm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  grad_req_t           q_head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MAG_BITS-1:0] out_gradient_magnitude,
  output logic                out_row_end,
  output logic                out_frame_end
);

  localparam int PROD_BITS = 2 * GRAD_BITS;
  localparam int SQ_BITS   = 2 * GRAD_BITS - 2;
  localparam int SUM_BITS  = SQ_BITS + 1;
  localparam int RAD_BITS  = 2 * MAG_BITS;
  localparam int REM_BITS  = MAG_BITS + 2;
  localparam int STEPS     = MAG_BITS;

  typedef struct packed {
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    logic [MAG_BITS-1:0] root;
    logic                sat;
    logic                row_end;
    logic                frame_end;
  } sqrt_stage_t;

  logic                        adv;
  logic signed [PROD_BITS-1:0] prod_x, prod_y;
  logic                        sq_vld_r, sq_row_r, sq_frame_r;
  logic [SQ_BITS-1:0]          sq_x_r, sq_y_r;
  logic [SUM_BITS-1:0]         sum;
  sqrt_stage_t                 st_r   [STEPS+1];
  sqrt_stage_t                 st_nxt [STEPS];
  logic                        vld_r  [STEPS+1];
  logic                        out_valid_r;
  logic [MAG_BITS-1:0]         out_mag_r;
  logic                        out_row_r, out_frame_r;

  // whole pipeline moves together whenever the output slot frees up
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign prod_x = q_head.gx * q_head.gx;
  assign prod_y = q_head.gy * q_head.gy;
  assign sum    = SUM_BITS'(sq_x_r) + SUM_BITS'(sq_y_r);

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [REM_BITS+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {st_r[k].rem, st_r[k].rad[RAD_BITS-1 -: 2]};
      trial  = {2'b00, st_r[k].root, 2'b01};
      st_nxt[k] = st_r[k];
      st_nxt[k].rad = {st_r[k].rad[RAD_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        st_nxt[k].rem  = REM_BITS'(rem_sh - trial);
        st_nxt[k].root = {st_r[k].root[MAG_BITS-2:0], 1'b1};
      end else begin
        st_nxt[k].rem  = REM_BITS'(rem_sh);
        st_nxt[k].root = {st_r[k].root[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      sq_vld_r    <= !q_empty;
      vld_r[0]    <= sq_vld_r;
      for (int k = 0; k < STEPS; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      out_valid_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r     <= prod_x[SQ_BITS-1:0];
      sq_y_r     <= prod_y[SQ_BITS-1:0];
      sq_row_r   <= q_head.row_end;
      sq_frame_r <= q_head.frame_end;

      st_r[0].rad       <= sum[RAD_BITS-1:0];
      st_r[0].rem       <= '0;
      st_r[0].root      <= '0;
      st_r[0].sat       <= (sum[SUM_BITS-1:RAD_BITS] != '0);
      st_r[0].row_end   <= sq_row_r;
      st_r[0].frame_end <= sq_frame_r;
      for (int k = 0; k < STEPS; k++) begin
        st_r[k+1] <= st_nxt[k];
      end

      out_mag_r   <= st_r[STEPS].sat ? MAG_BITS'(MAG_MAX) : st_r[STEPS].root;
      out_row_r   <= st_r[STEPS].row_end;
      out_frame_r <= st_r[STEPS].frame_end;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_gradient_magnitude = out_mag_r;
  assign out_row_end            = out_row_r;
  assign out_frame_end          = out_frame_r;

endmodule

/* src/sobel_gradient_magnitude_unit.sv */
// 3x3 sobel gradient magnitude over a raster stream of 8-bit gray pixels.
// pixels enter one per request on the in_ channel; frame_start marks row 0,
// column 0 and clears the position counters, though frames that follow each
// other need not carry it. for each interior pixel the block emits
// floor(sqrt(gx^2 + gy^2)) clamped to 255, once the pixel below and right of
// it has arrived; the first and last rows and columns give no result.
// row_end flags the last result of a row, frame_end the last of the frame.
// throughput is one pixel per clock while the result side keeps up: the
// line store is a single two-row memory with one read and one write port per
// clock, and the back end is a fully pipelined squarer and eight-step root.
// a result passes the front's pixel register, the queue, the squares register,
// the root steps and the output register.
// image_width (reg 0, byte 0x0) is used clamped to [3, MAX_WIDTH] and
// image_height (reg 1, byte 0x4) clamped to at least 3; change them only
// while the block is idle. line memory comes up undefined and needs no
// clearing pass.
module sobel_gradient_magnitude_unit import sgm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // pixel requests
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIXEL_BITS-1:0]    in_pixel_value,
  input  logic                     in_frame_start,
  // magnitude results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MAG_BITS-1:0]      out_gradient_magnitude,
  output logic                     out_row_end,
  output logic                     out_frame_end,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_dims_t dims_r;
  cfg_reg_t  reg_sel;
  logic      cfg_wr;

  logic      q_push, q_full, q_pop, q_empty;
  grad_req_t q_entry, q_head;

  // register file: word index taken from the address, low bits ignored
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_BITS'(dims_r.image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_BITS'(dims_r.image_height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.image_width  <= CFG_WIDTH_BITS'(WIDTH_RESET);
      dims_r.image_height <= CFG_HEIGHT_BITS'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  dims_r.image_width  <= pwdata[CFG_WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: dims_r.image_height <= pwdata[CFG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking, line memory, window and sobel sums
  sgm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .dims          (dims_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_value(in_pixel_value),
    .in_frame_start(in_frame_start),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .q_full        (q_full)
  );

  // short queue so border pixels keep flowing while the back end is held
  sgm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: squares, sum, saturation and pipelined integer root
  sgm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_head                (q_head),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_gradient_magnitude(out_gradient_magnitude),
    .out_row_end           (out_row_end),
    .out_frame_end         (out_frame_end)
  );

  // the front must never push into a full queue
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("sobel queue written while full");

  // the back must never pop an empty queue
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("sobel queue read while empty");

  // the last result of a frame is also the last of its row
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_row_end)
    else $error("frame end flagged without row end");

endmodule

/* tb/sv/tb_sobel_gradient_magnitude_unit.sv */
`timescale 1ns / 100ps

module tb_sobel_gradient_magnitude_unit;
  import sgm_pkg::*;

  // settle time after the last result
  localparam int SETTLE_CYCLES  = 32;
  localparam int DRAIN_SPIN_MAX = 40000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES    = 400;

  // random phases: register values (raw, before clamping), pixel count, no-idle flag
  localparam int NUM_PHASES = 8;
  localparam int PH_WIDTH  [NUM_PHASES] = '{0, 4, 33, 16, 4095, 5, 7, 3};
  localparam int PH_HEIGHT [NUM_PHASES] = '{1, 5, 6, 0, 3, 65535, 4, 3};
  localparam int PH_ITEMS  [NUM_PHASES] = '{80, 120, 250, 120, 60, 150, 150, 100};
  localparam bit PH_QUIET  [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam int PAUSE_PHASE = 1;
  localparam int HOLD_PHASE  = 2;

  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                row_end;
    logic                frame_end;
  } magnitude_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;
    logic                  typed;
    logic [MAG_BITS-1:0]   mag;
    logic                  row_end;
    logic                  frame_end;
  } directed_row_t;

  // three 3x3 frames; only the last pixel of each one completes an interior pixel
  localparam directed_row_t DIRECTED_ROWS [27] = '{
    // all black, first frame after reset
    '{8'd0, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b1},
    // right column white, no frame flag: counters wrapped on their own, gx saturates
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd255, 1'b0, 1'b1, 8'd255, 1'b1, 1'b1},
    // white top row over a mixed row, left to the predictor
    '{8'd255, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd17, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd128, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd200, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
    '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}
  };

  // block ports, the inputs all known from time zero
  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic [PIXEL_BITS-1:0]    in_pixel_value = '0;
  logic                     in_frame_start = 1'b0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic [MAG_BITS-1:0]      out_gradient_magnitude;
  logic                     out_row_end;
  logic                     out_frame_end;
  logic                     psel           = 1'b0;
  logic                     penable        = 1'b0;
  logic                     pwrite         = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr          = '0;
  logic [CFG_DATA_BITS-1:0] pwdata         = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // predictor copy of registers, line memory, window and raster position
  bit [CFG_WIDTH_BITS-1:0]  model_width  = CFG_WIDTH_BITS'(WIDTH_RESET);
  bit [CFG_HEIGHT_BITS-1:0] model_height = CFG_HEIGHT_BITS'(HEIGHT_RESET);
  bit [PIXEL_BITS-1:0]      row_two_up [MAX_WIDTH_DEF];
  bit [PIXEL_BITS-1:0]      row_one_up [MAX_WIDTH_DEF];
  bit [PIXEL_BITS-1:0]      win_top [2];
  bit [PIXEL_BITS-1:0]      win_mid [2];
  bit [PIXEL_BITS-1:0]      win_bot [2];
  int unsigned              col_pos = 0;
  int unsigned              row_pos = 0;
  // narrowest width used since the frame began at the origin
  int unsigned              frame_min_width = 0;

  magnitude_t pending_magnitudes [$];
  int         error_count = 0;

  // receiver control: stimulus only writes these, the stall process only reads
  int hold_requests = 0;
  bit quiet_phase   = 1'b0;
  // owned by the stall process
  int hold_served = 0;
  int hold_left   = 0;
  int burst_left  = 0;

  sobel_gradient_magnitude_unit #(
    .MAX_WIDTH(MAX_WIDTH_DEF)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pixel_value        (in_pixel_value),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_gradient_magnitude(out_gradient_magnitude),
    .out_row_end           (out_row_end),
    .out_frame_end         (out_frame_end),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] gradient check: %s", $time, what);
    error_count++;
  endtask

  function automatic int unsigned clamp_width(input int unsigned raw);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return raw;
  endfunction

  // floor of the square root, built one result bit at a time from the top;
  // anything at or above 2^16 is past 255 anyway
  function automatic logic [MAG_BITS-1:0] root_saturated(input int unsigned sum);
    logic [MAG_BITS-1:0] root;
    logic [MAG_BITS-1:0] trial;
    if (sum >= 32'd65536) return MAG_BITS'(MAG_MAX);
    root = '0;
    for (int b = MAG_BITS - 1; b >= 0; b--) begin
      trial = root | (MAG_BITS'(1) << b);
      if (32'(trial) * 32'(trial) <= sum) root = trial;
    end
    return root;
  endfunction

  // advance the predictor by one accepted pixel
  task automatic predict_pixel(input logic [PIXEL_BITS-1:0] px, input logic fs,
                               output bit produced, output magnitude_t res);
    int unsigned w, h, c, idx, sum;
    int t0, m0, b0, t1, b1, t2, m2, b2, gx, gy;
    bit last_col, last_row;
    w = clamp_width(model_width);
    h = (model_height < MIN_DIM) ? MIN_DIM : model_height;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos == 0 && row_pos == 0) frame_min_width = w;
    else if (w < frame_min_width) frame_min_width = w;
    c   = col_pos;
    idx = (c < MAX_WIDTH_DEF) ? c : MAX_WIDTH_DEF - 1;
    // arriving column: two rows up, one row up, this pixel
    t2 = row_two_up[idx];
    m2 = row_one_up[idx];
    b2 = px;
    row_two_up[idx] = row_one_up[idx];
    row_one_up[idx] = px;
    last_col = (c + 1 >= w);
    last_row = (row_pos + 1 >= h);
    produced = (row_pos >= 2 && c >= 2);
    res = '0;
    if (produced) begin
      t0 = win_top[0];
      m0 = win_mid[0];
      b0 = win_bot[0];
      t1 = win_top[1];
      b1 = win_bot[1];
      gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
      gy = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
      sum = gx * gx + gy * gy;
      res.mag       = root_saturated(sum);
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
    end
    win_top[0] = win_top[1];
    win_mid[0] = win_mid[1];
    win_bot[0] = win_bot[1];
    win_top[1] = t2[PIXEL_BITS-1:0];
    win_mid[1] = m2[PIXEL_BITS-1:0];
    win_bot[1] = px;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // write a register through setup and access, then read it back
  task automatic cfg_write_reg(input cfg_reg_t which, input logic [CFG_DATA_BITS-1:0] value);
    logic [CFG_DATA_BITS-1:0] field_mask;
    logic [CFG_DATA_BITS-1:0] seen;
    field_mask = (which == REG_IMAGE_WIDTH) ? CFG_DATA_BITS'((1 << CFG_WIDTH_BITS) - 1)
                                            : CFG_DATA_BITS'((1 << CFG_HEIGHT_BITS) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(int'(which) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (seen !== (value & field_mask))
      flag_mismatch($sformatf("register %s read 0x%0h, wrote 0x%0h",
                              which.name(), seen, value));
    if (which == REG_IMAGE_WIDTH) model_width = value[CFG_WIDTH_BITS-1:0];
    else model_height = value[CFG_HEIGHT_BITS-1:0];
  endtask

  // hold a pixel request until an edge sees it with no stall
  task automatic offer_pixel(input logic [PIXEL_BITS-1:0] px, input logic fs);
    in_valid       <= 1'b1;
    in_pixel_value <= px;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned sender_gap(input bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // wait for every expected result, then let rows that give no result retire
  task automatic wait_drained();
    int spins;
    spins = 0;
    while (pending_magnitudes.size() != 0 && spins < DRAIN_SPIN_MAX) begin
      @(posedge clk);
      spins++;
    end
    if (pending_magnitudes.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_magnitudes.size()));
      pending_magnitudes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side stall: a requested long hold first, then random bursts
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_phase) begin
      out_stall <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left--;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      burst_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    end
  end

  // every accepted result against the oldest expectation
  always @(posedge clk) begin
    magnitude_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_magnitudes.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected", out_gradient_magnitude));
      end else begin
        want = pending_magnitudes.pop_front();
        if (out_gradient_magnitude !== want.mag)
          flag_mismatch($sformatf("magnitude %0d, expected %0d",
                                  out_gradient_magnitude, want.mag));
        if (out_row_end !== want.row_end)
          flag_mismatch($sformatf("row_end %b, expected %b", out_row_end, want.row_end));
        if (out_frame_end !== want.frame_end)
          flag_mismatch($sformatf("frame_end %b, expected %b", out_frame_end, want.frame_end));
      end
    end
  end

  initial begin
    int unsigned gap, new_w, roll;
    bit fresh, fs, produced;
    logic [PIXEL_BITS-1:0] px, prev_px;
    magnitude_t res, typed_res;
    prev_px = 8'd128;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the smallest size
    cfg_write_reg(REG_IMAGE_WIDTH, 32'd3);
    cfg_write_reg(REG_IMAGE_HEIGHT, 32'd3);
    for (int i = 0; i < 27; i++) begin
      gap = sender_gap(1'b0);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      offer_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].frame_start);
      predict_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].frame_start, produced, res);
      if (DIRECTED_ROWS[i].typed) begin
        typed_res.mag       = DIRECTED_ROWS[i].mag;
        typed_res.row_end   = DIRECTED_ROWS[i].row_end;
        typed_res.frame_end = DIRECTED_ROWS[i].frame_end;
        pending_magnitudes.push_back(typed_res);
      end else if (produced) begin
        pending_magnitudes.push_back(res);
      end
    end
    in_valid <= 1'b0;

    // random phases over a range of frame sizes
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      // the frame may carry on across the change only if no line entry
      // it will read is left unwritten, i.e. the width does not grow
      new_w = clamp_width(PH_WIDTH[p]);
      fresh = !(new_w <= frame_min_width && $urandom_range(0, 1) == 1);
      cfg_write_reg(REG_IMAGE_WIDTH, PH_WIDTH[p]);
      cfg_write_reg(REG_IMAGE_HEIGHT, PH_HEIGHT[p]);
      quiet_phase <= PH_QUIET[p];
      if (p == HOLD_PHASE) hold_requests <= hold_requests + 1;
      for (int k = 0; k < PH_ITEMS[p]; k++) begin
        // sender stops and lets the block empty out
        if (p == PAUSE_PHASE && k == PH_ITEMS[p] / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        gap = sender_gap(PH_QUIET[p]);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        // frame flag at the origin either way, now and then a broken frame
        if (k == 0) fs = fresh;
        else if (col_pos == 0 && row_pos == 0) fs = ($urandom_range(0, 1) == 1);
        else fs = (new_w <= 64 && $urandom_range(0, 399) == 0);
        roll = $urandom_range(0, 9);
        if (roll < 6) px = 8'($urandom_range(0, 255));
        else if (roll < 8) px = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        else px = prev_px + 8'($urandom_range(0, 6)) - 8'd3;
        prev_px = px;
        offer_pixel(px, fs);
        predict_pixel(px, fs, produced, res);
        if (produced) pending_magnitudes.push_back(res);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // safety net well past the slowest legal run
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
